// ===== design/csp_pkg.sv =====
package csp_pkg;

	localparam int SW = 11;
	localparam int CW = 10;
	localparam int IW = 30;
	localparam int VW = 34;
	localparam int DW = 13;
	localparam int FW = 3;
	localparam int RIW = 3;
	localparam int QDEPTH = 4;
	localparam int MAX_RES_DEF = 1024;

	localparam logic CMD_ENCODE = 1'b0;
	localparam logic CMD_DECODE = 1'b1;

	localparam logic [FW-1:0] FACE_AUTO = 3'd0;
	localparam logic [FW-1:0] FACE_X0 = 3'd1;
	localparam logic [FW-1:0] FACE_X1 = 3'd2;
	localparam logic [FW-1:0] FACE_Y0 = 3'd3;
	localparam logic [FW-1:0] FACE_Y1 = 3'd4;
	localparam logic [FW-1:0] FACE_Z0 = 3'd5;
	localparam logic [FW-1:0] FACE_Z1 = 3'd6;
	localparam logic [FW-1:0] FACE_ALT_AUTO = 3'd7;

	localparam logic [RIW-1:0] REG_SIZE_X = 3'd0;
	localparam logic [RIW-1:0] REG_SIZE_Y = 3'd1;
	localparam logic [RIW-1:0] REG_SIZE_Z = 3'd2;
	localparam logic [RIW-1:0] REG_SPLIT = 3'd3;
	localparam logic [RIW-1:0] REG_KEEP = 3'd4;

	typedef enum logic [1:0] {MODE_SPLIT, MODE_SURF, MODE_LATTICE} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_PRE, ST_PRE2, ST_ENC1, ST_ENC2, ST_DEC0, ST_DIV, ST_DEC_MID, ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		DIV_SPLIT_YZ, DIV_SPLIT_XZ, DIV_SPLIT_XY, DIV_CAP0, DIV_CAP1, DIV_RING,
		DIV_LAT1, DIV_LAT2
	} div_sel_t;

	typedef struct packed {
		logic [SW-1:0] size_x;
		logic [SW-1:0] size_y;
		logic [SW-1:0] size_z;
		logic split_faces;
		logic keep_interior;
	} cfg_t;

	typedef struct packed {
		logic command;
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [CW-1:0] z;
		logic [FW-1:0] face;
		logic [IW-1:0] index;
		mode_t mode;
	} item_t;

	function automatic logic [SW-1:0] eff_size(logic [SW-1:0] s, int unsigned max_res);
		logic [SW-1:0] r;
		r = s;
		if (s == '0) begin
			r = SW'(1);
		end else if ({21'b0, s} > max_res) begin
			r = max_res[SW-1:0];
		end
		return r;
	endfunction

endpackage

// ===== design/cube_surface_point_index_map_top.sv =====
// Channel   Handshake               Payload
// input     start high, busy low    command, in_x, in_y, in_z, face, in_index
// config    cfg_valid, cfg_ready    cfg_index, cfg_data
// result    done, one cycle         out_index, out_x, out_y, out_z, in_range
// An encode item passes PRE, PRE2, ENC1 and ENC2 in the back end, a decode item PRE, PRE2,
// DEC0, the serial divider and DEC_MID (straight to DONE when the index is beyond the point
// count); in full lattice mode the divider, producing one quotient bit a cycle, runs twice.
// A four-item queue lets the front accept items while the back end works; busy means it is full.
// Reset clears the configuration to sizes of 1 and both flags low, and empties the queue.
// The receiver cannot stall, so every result leaves on its done cycle.
module cube_surface_point_index_map_top #(
	parameter int MAX_RES = csp_pkg::MAX_RES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic command,
	input  logic [csp_pkg::CW-1:0] in_x,
	input  logic [csp_pkg::CW-1:0] in_y,
	input  logic [csp_pkg::CW-1:0] in_z,
	input  logic [csp_pkg::FW-1:0] face,
	input  logic [csp_pkg::IW-1:0] in_index,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [csp_pkg::RIW-1:0] cfg_index,
	input  logic [csp_pkg::SW-1:0] cfg_data,
	output logic done,
	output logic [csp_pkg::IW-1:0] out_index,
	output logic [csp_pkg::CW-1:0] out_x,
	output logic [csp_pkg::CW-1:0] out_y,
	output logic [csp_pkg::CW-1:0] out_z,
	output logic in_range
);

	csp_pkg::cfg_t cfg;
	csp_pkg::item_t head;
	logic head_valid;
	logic pop;

	csp_front #(.MAX_RES(MAX_RES)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.in_x(in_x),
		.in_y(in_y),
		.in_z(in_z),
		.face(face),
		.in_index(in_index),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg),
		.head(head),
		.head_valid(head_valid),
		.pop(pop)
	);

	csp_back #(.MAX_RES(MAX_RES)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.head(head),
		.head_valid(head_valid),
		.pop(pop),
		.done(done),
		.out_index(out_index),
		.out_x(out_x),
		.out_y(out_y),
		.out_z(out_z),
		.in_range(in_range)
	);

endmodule

// ===== design/csp_front.sv =====
module csp_front #(
	parameter int MAX_RES = csp_pkg::MAX_RES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic command,
	input  logic [csp_pkg::CW-1:0] in_x,
	input  logic [csp_pkg::CW-1:0] in_y,
	input  logic [csp_pkg::CW-1:0] in_z,
	input  logic [csp_pkg::FW-1:0] face,
	input  logic [csp_pkg::IW-1:0] in_index,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [csp_pkg::RIW-1:0] cfg_index,
	input  logic [csp_pkg::SW-1:0] cfg_data,
	output csp_pkg::cfg_t cfg,
	output csp_pkg::item_t head,
	output logic head_valid,
	input  logic pop
);

	localparam int QD = csp_pkg::QDEPTH;
	localparam int PW = $clog2(QD);
	localparam int NW = $clog2(QD + 1);

	csp_pkg::cfg_t cfg_q;
	csp_pkg::item_t mem_q [QD];
	logic [PW-1:0] wp_q, rp_q;
	logic [NW-1:0] cnt_q;
	logic push;
	logic [csp_pkg::SW-1:0] nx, ny, nz;
	csp_pkg::item_t item;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;
	assign busy = (cnt_q == NW'(QD));
	assign push = start && !busy;
	assign head = mem_q[rp_q];
	assign head_valid = (cnt_q != '0);

	assign nx = csp_pkg::eff_size(cfg_q.size_x, MAX_RES);
	assign ny = csp_pkg::eff_size(cfg_q.size_y, MAX_RES);
	assign nz = csp_pkg::eff_size(cfg_q.size_z, MAX_RES);

	always_comb begin
		item.command = command;
		item.x = in_x;
		item.y = in_y;
		item.z = in_z;
		item.face = face;
		item.index = in_index;
		if (cfg_q.split_faces) begin
			item.mode = csp_pkg::MODE_SPLIT;
		end else if (!cfg_q.keep_interior && nx > 1 && ny > 1 && nz > 1) begin
			item.mode = csp_pkg::MODE_SURF;
		end else begin
			item.mode = csp_pkg::MODE_LATTICE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.size_x <= csp_pkg::SW'(1);
			cfg_q.size_y <= csp_pkg::SW'(1);
			cfg_q.size_z <= csp_pkg::SW'(1);
			cfg_q.split_faces <= 1'b0;
			cfg_q.keep_interior <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				csp_pkg::REG_SIZE_X: cfg_q.size_x <= cfg_data;
				csp_pkg::REG_SIZE_Y: cfg_q.size_y <= cfg_data;
				csp_pkg::REG_SIZE_Z: cfg_q.size_z <= cfg_data;
				csp_pkg::REG_SPLIT: cfg_q.split_faces <= cfg_data[0];
				csp_pkg::REG_KEEP: cfg_q.keep_interior <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= item;
		end
	end

endmodule

// ===== design/csp_back.sv =====
module csp_back #(
	parameter int MAX_RES = csp_pkg::MAX_RES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  csp_pkg::cfg_t cfg,
	input  csp_pkg::item_t head,
	input  logic head_valid,
	output logic pop,
	output logic done,
	output logic [csp_pkg::IW-1:0] out_index,
	output logic [csp_pkg::CW-1:0] out_x,
	output logic [csp_pkg::CW-1:0] out_y,
	output logic [csp_pkg::CW-1:0] out_z,
	output logic in_range
);

	localparam int SW = csp_pkg::SW;
	localparam int CW = csp_pkg::CW;
	localparam int IW = csp_pkg::IW;
	localparam int VW = csp_pkg::VW;
	localparam int DW = csp_pkg::DW;
	localparam int FW = csp_pkg::FW;
	localparam int TW = $clog2(IW);

	csp_pkg::state_t state_q, state_d;
	csp_pkg::item_t it_q, it_d;
	csp_pkg::div_sel_t sel_q, sel_d;
	logic [SW-1:0] nx_q, ny_q, nz_q, nx_d, ny_d, nz_d;
	logic [FW-1:0] face_q, face_d;
	logic [VW-1:0] nxny_q, nynz_q, nxnz_q, half_q, count_q, p1_q;
	logic [VW-1:0] nxny_d, nynz_d, nxnz_d, half_d, count_d, p1_d;
	logic [DW-1:0] ring_q, ring_d, dvs_q, dvs_d, rem_q, rem_d;
	logic [IW-1:0] dvd_q, dvd_d;
	logic [TW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] ox_q, oy_q, oz_q, ox_d, oy_d, oz_d;
	logic [IW-1:0] res_index_q, res_index_d;
	logic [CW-1:0] res_x_q, res_y_q, res_z_q, res_x_d, res_y_d, res_z_d;
	logic res_ok_q, res_ok_d;

	logic [VW-1:0] vx, vy, vz, vnx, vny, vnz, idx, base, i1, j1;
	logic [DW-1:0] r, nx2;
	logic [DW:0] rem_sh;
	logic inr;

	assign vx = VW'(it_q.x);
	assign vy = VW'(it_q.y);
	assign vz = VW'(it_q.z);
	assign vnx = VW'(nx_q);
	assign vny = VW'(ny_q);
	assign vnz = VW'(nz_q);
	assign r = rem_q;
	assign nx2 = DW'({nx_q, 1'b0});
	assign rem_sh = {rem_q, dvd_q[IW-1]};

	assign done = (state_q == csp_pkg::ST_DONE);
	assign out_index = res_index_q;
	assign out_x = res_x_q;
	assign out_y = res_y_q;
	assign out_z = res_z_q;
	assign in_range = res_ok_q;

	always_comb begin
		state_d = state_q;
		it_d = it_q;
		sel_d = sel_q;
		nx_d = nx_q;
		ny_d = ny_q;
		nz_d = nz_q;
		face_d = face_q;
		nxny_d = nxny_q;
		nynz_d = nynz_q;
		nxnz_d = nxnz_q;
		half_d = half_q;
		count_d = count_q;
		p1_d = p1_q;
		ring_d = ring_q;
		dvs_d = dvs_q;
		rem_d = rem_q;
		dvd_d = dvd_q;
		cnt_d = cnt_q;
		ox_d = ox_q;
		oy_d = oy_q;
		oz_d = oz_q;
		res_index_d = res_index_q;
		res_x_d = res_x_q;
		res_y_d = res_y_q;
		res_z_d = res_z_q;
		res_ok_d = res_ok_q;
		pop = 1'b0;
		idx = '0;
		base = '0;
		i1 = '0;
		j1 = '0;
		inr = 1'b0;
		unique case (state_q)
			csp_pkg::ST_IDLE: begin
				if (head_valid) begin
					pop = 1'b1;
					it_d = head;
					nx_d = csp_pkg::eff_size(cfg.size_x, MAX_RES);
					ny_d = csp_pkg::eff_size(cfg.size_y, MAX_RES);
					nz_d = csp_pkg::eff_size(cfg.size_z, MAX_RES);
					state_d = csp_pkg::ST_PRE;
				end
			end
			csp_pkg::ST_PRE: begin
				nxny_d = vnx * vny;
				nynz_d = vny * vnz;
				nxnz_d = vnx * vnz;
				ring_d = DW'({nx_q, 1'b0}) + DW'({ny_q, 1'b0}) - DW'(4);
				face_d = it_q.face;
				if (it_q.face == csp_pkg::FACE_AUTO || it_q.face == csp_pkg::FACE_ALT_AUTO) begin
					priority if (vx == '0) face_d = csp_pkg::FACE_X0;
					else if (vx == vnx - 1'b1) face_d = csp_pkg::FACE_X1;
					else if (vy == '0) face_d = csp_pkg::FACE_Y0;
					else if (vy == vny - 1'b1) face_d = csp_pkg::FACE_Y1;
					else if (vz == '0) face_d = csp_pkg::FACE_Z0;
					else if (vz == vnz - 1'b1) face_d = csp_pkg::FACE_Z1;
					else face_d = csp_pkg::FACE_AUTO;
				end
				state_d = csp_pkg::ST_PRE2;
			end
			csp_pkg::ST_PRE2: begin
				half_d = nynz_q + nxnz_q + nxny_q;
				unique case (it_q.mode)
					csp_pkg::MODE_SPLIT: begin
						count_d = ((nz_q > 1) ? {nxny_q[VW-2:0], 1'b0} : nxny_q)
							+ ((nx_q > 1) ? {nynz_q[VW-2:0], 1'b0} : nynz_q)
							+ ((ny_q > 1) ? {nxnz_q[VW-2:0], 1'b0} : nxnz_q);
					end
					csp_pkg::MODE_SURF: begin
						count_d = {nxny_q[VW-2:0], 1'b0} + (vnz - VW'(2)) * VW'(ring_q);
					end
					default: count_d = nxny_q * vnz;
				endcase
				state_d = (it_q.command == csp_pkg::CMD_ENCODE) ? csp_pkg::ST_ENC1
					: csp_pkg::ST_DEC0;
			end
			csp_pkg::ST_ENC1: begin
				unique case (it_q.mode)
					csp_pkg::MODE_SPLIT: begin
						if (face_q == csp_pkg::FACE_X0 || face_q == csp_pkg::FACE_X1) begin
							p1_d = vny * vz;
						end else if (face_q == csp_pkg::FACE_Y0 || face_q == csp_pkg::FACE_Y1) begin
							p1_d = vnx * vz;
						end else begin
							p1_d = vnx * vy;
						end
					end
					csp_pkg::MODE_SURF: begin
						if (vz == '0) begin
							p1_d = vnx * vy;
						end else if (vz == vnz - 1'b1) begin
							p1_d = vnx * (vy + vny);
						end else begin
							p1_d = VW'(ring_q) * (vz - 1'b1);
						end
					end
					default: p1_d = vny * vz;
				endcase
				state_d = csp_pkg::ST_ENC2;
			end
			csp_pkg::ST_ENC2: begin
				inr = (vx < vnx) && (vy < vny) && (vz < vnz);
				unique case (it_q.mode)
					csp_pkg::MODE_SPLIT: begin
						unique case (face_q)
							csp_pkg::FACE_X0: idx = vy + p1_q;
							csp_pkg::FACE_X1: idx = half_q + vy + p1_q;
							csp_pkg::FACE_Y0: idx = nynz_q + vx + p1_q;
							csp_pkg::FACE_Y1: idx = half_q + nynz_q + vx + p1_q;
							csp_pkg::FACE_Z0: idx = nynz_q + nxnz_q + vx + p1_q;
							csp_pkg::FACE_Z1: idx = half_q + nynz_q + nxnz_q + vx + p1_q;
							default: idx = '0;
						endcase
					end
					csp_pkg::MODE_SURF: begin
						base = {nxny_q[VW-2:0], 1'b0} + p1_q;
						priority if (vz == '0 || vz == vnz - 1'b1) idx = vx + p1_q;
						else if (vy == '0) idx = base + vx;
						else if (vy == vny - 1'b1) idx = base + vx + vnx;
						else if (vx == '0) idx = base + {vnx[VW-2:0], 1'b0} + vy - 1'b1;
						else idx = base + {vnx[VW-2:0], 1'b0} + vny - VW'(3) + vy;
					end
					default: idx = vx + vnx * (vy + p1_q);
				endcase
				res_ok_d = inr;
				res_index_d = inr ? idx[IW-1:0] : '0;
				res_x_d = '0;
				res_y_d = '0;
				res_z_d = '0;
				state_d = csp_pkg::ST_DONE;
			end
			csp_pkg::ST_DEC0: begin
				rem_d = '0;
				cnt_d = '0;
				if (VW'(it_q.index) < count_q) begin
					state_d = csp_pkg::ST_DIV;
					ox_d = '0;
					oy_d = '0;
					oz_d = '0;
					unique case (it_q.mode)
						csp_pkg::MODE_SPLIT: begin
							i1 = VW'(it_q.index);
							if (i1 >= half_q) begin
								i1 = i1 - half_q;
								ox_d = CW'(nx_q - 1'b1);
								oy_d = CW'(ny_q - 1'b1);
								oz_d = CW'(nz_q - 1'b1);
							end
							j1 = i1 - nynz_q;
							if (i1 < nynz_q) begin
								dvd_d = i1[IW-1:0];
								dvs_d = DW'(ny_q);
								sel_d = csp_pkg::DIV_SPLIT_YZ;
							end else if (j1 < nxnz_q) begin
								dvd_d = j1[IW-1:0];
								dvs_d = DW'(nx_q);
								sel_d = csp_pkg::DIV_SPLIT_XZ;
							end else begin
								j1 = j1 - nxnz_q;
								dvd_d = j1[IW-1:0];
								dvs_d = DW'(nx_q);
								sel_d = csp_pkg::DIV_SPLIT_XY;
							end
						end
						csp_pkg::MODE_SURF: begin
							i1 = VW'(it_q.index);
							if (i1 < nxny_q) begin
								dvd_d = it_q.index;
								dvs_d = DW'(nx_q);
								sel_d = csp_pkg::DIV_CAP0;
							end else if (i1 < {nxny_q[VW-2:0], 1'b0}) begin
								j1 = i1 - nxny_q;
								dvd_d = j1[IW-1:0];
								dvs_d = DW'(nx_q);
								sel_d = csp_pkg::DIV_CAP1;
							end else begin
								j1 = i1 - {nxny_q[VW-2:0], 1'b0};
								dvd_d = j1[IW-1:0];
								dvs_d = ring_q;
								sel_d = csp_pkg::DIV_RING;
							end
						end
						default: begin
							dvd_d = it_q.index;
							dvs_d = DW'(nx_q);
							sel_d = csp_pkg::DIV_LAT1;
						end
					endcase
				end else begin
					res_ok_d = 1'b0;
					res_index_d = '0;
					res_x_d = '0;
					res_y_d = '0;
					res_z_d = '0;
					state_d = csp_pkg::ST_DONE;
				end
			end
			csp_pkg::ST_DIV: begin
				if (rem_sh >= {1'b0, dvs_q}) begin
					rem_d = DW'(rem_sh - {1'b0, dvs_q});
					dvd_d = {dvd_q[IW-2:0], 1'b1};
				end else begin
					rem_d = rem_sh[DW-1:0];
					dvd_d = {dvd_q[IW-2:0], 1'b0};
				end
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == TW'(IW - 1)) begin
					state_d = csp_pkg::ST_DEC_MID;
				end
			end
			csp_pkg::ST_DEC_MID: begin
				res_ok_d = 1'b1;
				res_index_d = '0;
				res_x_d = ox_q;
				res_y_d = oy_q;
				res_z_d = oz_q;
				state_d = csp_pkg::ST_DONE;
				unique case (sel_q)
					csp_pkg::DIV_SPLIT_YZ: begin
						res_y_d = CW'(r);
						res_z_d = dvd_q[CW-1:0];
					end
					csp_pkg::DIV_SPLIT_XZ: begin
						res_x_d = CW'(r);
						res_z_d = dvd_q[CW-1:0];
					end
					csp_pkg::DIV_SPLIT_XY: begin
						res_x_d = CW'(r);
						res_y_d = dvd_q[CW-1:0];
					end
					csp_pkg::DIV_CAP0: begin
						res_x_d = CW'(r);
						res_y_d = dvd_q[CW-1:0];
						res_z_d = '0;
					end
					csp_pkg::DIV_CAP1: begin
						res_x_d = CW'(r);
						res_y_d = dvd_q[CW-1:0];
						res_z_d = CW'(nz_q - 1'b1);
					end
					csp_pkg::DIV_RING: begin
						res_z_d = dvd_q[CW-1:0] + 1'b1;
						priority if (r < DW'(nx_q)) begin
							res_x_d = CW'(r);
							res_y_d = '0;
						end else if (r < nx2) begin
							res_x_d = CW'(r - DW'(nx_q));
							res_y_d = CW'(ny_q - 1'b1);
						end else if (r < nx2 + DW'(ny_q) - DW'(2)) begin
							res_x_d = '0;
							res_y_d = CW'(r - nx2 + DW'(1));
						end else begin
							res_x_d = CW'(nx_q - 1'b1);
							res_y_d = CW'(r - nx2 - DW'(ny_q) + DW'(3));
						end
					end
					csp_pkg::DIV_LAT1: begin
						ox_d = CW'(r);
						dvd_d = dvd_q;
						dvs_d = DW'(ny_q);
						rem_d = '0;
						cnt_d = '0;
						sel_d = csp_pkg::DIV_LAT2;
						state_d = csp_pkg::ST_DIV;
					end
					default: begin
						res_y_d = CW'(r);
						res_z_d = dvd_q[CW-1:0];
					end
				endcase
			end
			default: state_d = csp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		it_q <= it_d;
		sel_q <= sel_d;
		nx_q <= nx_d;
		ny_q <= ny_d;
		nz_q <= nz_d;
		face_q <= face_d;
		nxny_q <= nxny_d;
		nynz_q <= nynz_d;
		nxnz_q <= nxnz_d;
		half_q <= half_d;
		count_q <= count_d;
		p1_q <= p1_d;
		ring_q <= ring_d;
		dvs_q <= dvs_d;
		rem_q <= rem_d;
		dvd_q <= dvd_d;
		cnt_q <= cnt_d;
		ox_q <= ox_d;
		oy_q <= oy_d;
		oz_q <= oz_d;
		res_index_q <= res_index_d;
		res_x_q <= res_x_d;
		res_y_q <= res_y_d;
		res_z_q <= res_z_d;
		res_ok_q <= res_ok_d;
	end

endmodule
